>>> hdl/mtme_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the opcode length table of the track message extractor.
package mtme_pkg;

  typedef enum logic [2:0] {
    PH_OPCODE   = 3'd0,
    PH_SKIP     = 3'd1,
    PH_BLOCKLEN = 3'd2,
    PH_HEADER   = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_STOPPED  = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [7:0] OP_MESSAGE = 8'he1;
  localparam logic [7:0] OP_END     = 8'he2;
  localparam logic [7:0] OP_BLOCK   = 8'hbb;

  localparam logic [3:0] HDR_OWNER_LO = 4'd1;
  localparam logic [3:0] HDR_OWNER_HI = 4'd2;
  localparam logic [3:0] HDR_TYPE     = 4'd3;
  localparam logic [3:0] HDR_LEN_LO   = 4'd4;
  localparam logic [3:0] HDR_LEN_HI   = 4'd5;
  localparam logic [3:0] HDR_CONTROL  = 4'd6;
  localparam logic [3:0] HDR_BANK_LO  = 4'd7;
  localparam logic [3:0] HDR_BANK_HI  = 4'd8;
  localparam logic [3:0] HDR_SOUND    = 4'd9;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [15:0] bank;
    logic [15:0] plen;
    logic [7:0]  data;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [1:0] op_len(input logic [7:0] op);
    logic [1:0] len;
    len = 2'd0;
    unique case (op) inside
      [8'h00:8'h80], 8'h90, 8'ha2, 8'ha3, [8'ha5:8'hae], 8'hb1, 8'hb2, 8'hb9,
      8'hc1, 8'hd0, 8'he0: len = 2'd2;
      8'h91, 8'ha0, 8'ha1, 8'ha4, 8'haf, 8'hb0, 8'hb3, 8'hc4: len = 2'd3;
      [8'hb4:8'hb8], 8'hba, 8'hbb, 8'hd1, 8'hd2, 8'hda, 8'hdb, 8'he1, 8'he2,
      [8'hf0:8'hff]: len = 2'd1;
      default: len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

>>> hdl/music_track_message_extractor_unit.sv
`timescale 1ns / 1ps
// Top level of the music track message extractor.
// A result is written into the queue and then into the output register before it appears on the out_ ports.
// Throughput: one byte per cycle while in_stall is low; in_stall is high while the queue is full.
// A QUEUE_DEPTH-entry queue and the output register absorb stalls on the result side.
// Reset is synchronous and active low; it clears the parser, the queue and driver_id at once.
module music_track_message_extractor_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_track_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_bank,
  output logic [7:0]  out_sound_number,
  output logic [15:0] out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_record_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_driver_id
);

  mtme_pkg::q_status_t q_status;
  mtme_pkg::result_t   push_entry;
  mtme_pkg::result_t   pop_entry;
  logic                push;
  logic                pop;

  assign cfg_ready = 1'b1;

  mtme_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_track_end  (in_track_end),
    .cfg_valid     (cfg_valid),
    .cfg_driver_id (cfg_driver_id),
    .q_status      (q_status),
    .push          (push),
    .push_entry    (push_entry)
  );

  mtme_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_status   (q_status)
  );

  mtme_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_status           (q_status),
    .pop_entry          (pop_entry),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_bank           (out_bank),
    .out_sound_number   (out_sound_number),
    .out_payload_length (out_payload_length),
    .out_payload_byte   (out_payload_byte),
    .out_record_last    (out_record_last)
  );

endmodule

>>> hdl/mtme_front.sv
`timescale 1ns / 1ps
// Front part: accepts track bytes, walks the event structure and emits result entries.
module mtme_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_track_end,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_driver_id,
  input  mtme_pkg::q_status_t q_status,
  output logic                push,
  output mtme_pkg::result_t   push_entry
);

  mtme_pkg::phase_t  phase_r, phase_nxt;
  logic [15:0]       bytes_left_r, bytes_left_nxt;
  logic [3:0]        header_index_r, header_index_nxt;
  logic [15:0]       owner_id_r, owner_id_nxt;
  logic [7:0]        control_byte_r, control_byte_nxt;
  logic [15:0]       bank_held_r, bank_held_nxt;
  logic [15:0]       message_length_r, message_length_nxt;
  logic              record_selected_r, record_selected_nxt;
  logic [15:0]       driver_id_r;
  logic              accept;
  logic [1:0]        len;
  logic [15:0]       bl_dec;
  logic [15:0]       skip_n;
  logic [15:0]       len16;
  logic [15:0]       pl;
  logic              sel;
  logic              res_vld;
  logic              kept;
  mtme_pkg::result_t res;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign len      = mtme_pkg::op_len(in_data_byte);
  assign bl_dec   = bytes_left_r - 16'd1;
  assign skip_n   = (in_data_byte == 8'd0) ? 16'd1 : {8'd0, in_data_byte - 8'd1};
  assign len16    = {in_data_byte, message_length_r[7:0]};
  assign pl       = message_length_r - 16'd4;
  assign sel      = (owner_id_r == driver_id_r) && (control_byte_r == 8'd0);

  always_comb begin
    phase_nxt           = phase_r;
    bytes_left_nxt      = bytes_left_r;
    header_index_nxt    = header_index_r;
    owner_id_nxt        = owner_id_r;
    control_byte_nxt    = control_byte_r;
    bank_held_nxt       = bank_held_r;
    message_length_nxt  = message_length_r;
    record_selected_nxt = record_selected_r;
    res                 = '0;
    res_vld             = 1'b0;
    kept                = 1'b0;
    unique case (phase_r)
      mtme_pkg::PH_OPCODE: begin
        if (in_data_byte == mtme_pkg::OP_END) begin
          phase_nxt = mtme_pkg::PH_STOPPED;
        end else if (in_data_byte == mtme_pkg::OP_BLOCK) begin
          phase_nxt = mtme_pkg::PH_BLOCKLEN;
        end else if (in_data_byte == mtme_pkg::OP_MESSAGE) begin
          header_index_nxt = mtme_pkg::HDR_OWNER_LO;
          phase_nxt        = mtme_pkg::PH_HEADER;
        end else if (len == 2'd0) begin
          res.kind  = mtme_pkg::KIND_ERROR;
          res.data  = in_data_byte;
          res_vld   = 1'b1;
          phase_nxt = mtme_pkg::PH_STOPPED;
        end else begin
          bytes_left_nxt = {14'd0, len - 2'd1};
          phase_nxt = (len == 2'd1) ? mtme_pkg::PH_OPCODE : mtme_pkg::PH_SKIP;
        end
      end
      mtme_pkg::PH_SKIP: begin
        bytes_left_nxt = bl_dec;
        if (bl_dec == 16'd0) begin
          phase_nxt = mtme_pkg::PH_OPCODE;
        end
      end
      mtme_pkg::PH_BLOCKLEN: begin
        bytes_left_nxt = skip_n;
        phase_nxt = (skip_n == 16'd0) ? mtme_pkg::PH_OPCODE : mtme_pkg::PH_SKIP;
      end
      mtme_pkg::PH_HEADER: begin
        unique case (header_index_r)
          mtme_pkg::HDR_OWNER_LO: owner_id_nxt = {8'd0, in_data_byte};
          mtme_pkg::HDR_OWNER_HI: owner_id_nxt = {in_data_byte, owner_id_r[7:0]};
          mtme_pkg::HDR_TYPE: begin
          end
          mtme_pkg::HDR_LEN_LO: message_length_nxt = {8'd0, in_data_byte};
          mtme_pkg::HDR_LEN_HI: begin
            message_length_nxt = len16;
            if (len16 < 16'd4) begin
              res.kind  = mtme_pkg::KIND_ERROR;
              res.data  = mtme_pkg::OP_MESSAGE;
              res_vld   = 1'b1;
              phase_nxt = mtme_pkg::PH_STOPPED;
            end
          end
          mtme_pkg::HDR_CONTROL: control_byte_nxt = in_data_byte;
          mtme_pkg::HDR_BANK_LO: bank_held_nxt = {8'd0, in_data_byte};
          mtme_pkg::HDR_BANK_HI: bank_held_nxt = {in_data_byte, bank_held_r[7:0]};
          default: begin
            record_selected_nxt = sel;
            if (sel) begin
              res.kind = mtme_pkg::KIND_HEADER;
              res.bank = bank_held_r;
              res.data = in_data_byte;
              res.plen = pl;
              res.last = (pl == 16'd0);
              res_vld  = 1'b1;
              kept     = 1'b1;
            end
            bytes_left_nxt = pl;
            phase_nxt = (pl == 16'd0) ? mtme_pkg::PH_OPCODE : mtme_pkg::PH_PAYLOAD;
          end
        endcase
        if (phase_nxt == mtme_pkg::PH_HEADER) begin
          header_index_nxt = header_index_r + 4'd1;
        end
      end
      mtme_pkg::PH_PAYLOAD: begin
        bytes_left_nxt = bl_dec;
        if (record_selected_r) begin
          res.kind = mtme_pkg::KIND_PAYLOAD;
          res.data = in_data_byte;
          res.last = (bl_dec == 16'd0);
          res_vld  = 1'b1;
          kept     = 1'b1;
        end
        if (bl_dec == 16'd0) begin
          phase_nxt = mtme_pkg::PH_OPCODE;
        end
      end
      mtme_pkg::PH_STOPPED: begin
      end
      default: begin
        phase_nxt = mtme_pkg::PH_OPCODE;
      end
    endcase
    if (in_track_end) begin
      if (kept) begin
        res.last = 1'b1;
      end
      phase_nxt           = mtme_pkg::PH_OPCODE;
      bytes_left_nxt      = 16'd0;
      header_index_nxt    = 4'd0;
      owner_id_nxt        = 16'd0;
      control_byte_nxt    = 8'd0;
      bank_held_nxt       = 16'd0;
      message_length_nxt  = 16'd0;
      record_selected_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= mtme_pkg::PH_OPCODE;
      bytes_left_r      <= 16'd0;
      header_index_r    <= 4'd0;
      owner_id_r        <= 16'd0;
      control_byte_r    <= 8'd0;
      bank_held_r       <= 16'd0;
      message_length_r  <= 16'd0;
      record_selected_r <= 1'b0;
    end else if (accept) begin
      phase_r           <= phase_nxt;
      bytes_left_r      <= bytes_left_nxt;
      header_index_r    <= header_index_nxt;
      owner_id_r        <= owner_id_nxt;
      control_byte_r    <= control_byte_nxt;
      bank_held_r       <= bank_held_nxt;
      message_length_r  <= message_length_nxt;
      record_selected_r <= record_selected_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      driver_id_r <= 16'd0;
    end else if (cfg_valid) begin
      driver_id_r <= cfg_driver_id;
    end
  end

  assign push       = accept && res_vld;
  assign push_entry = res;

  a_header_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    header_index_r <= mtme_pkg::HDR_SOUND)
    else $error("Header index ran past the sound number byte.");

  a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_entry.kind == mtme_pkg::KIND_ERROR |=>
      phase_r == mtme_pkg::PH_STOPPED || phase_r == mtme_pkg::PH_OPCODE)
    else $error("Parser kept running after a format error.");

endmodule

>>> hdl/mtme_queue.sv
`timescale 1ns / 1ps
// Short result queue between the parser and the output stage.
module mtme_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mtme_pkg::result_t   push_entry,
  input  logic                pop,
  output mtme_pkg::result_t   pop_entry,
  output mtme_pkg::q_status_t q_status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mtme_pkg::result_t mem [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_pop;

  assign do_pop         = pop && !q_status.empty;
  assign q_status.full  = (count_r == CW'(DEPTH));
  assign q_status.empty = (count_r == '0);
  assign pop_entry      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("Queue fill count exceeds its depth.");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_status.full))
    else $error("Request written into a full queue.");

endmodule

>>> hdl/mtme_back.sv
`timescale 1ns / 1ps
// Back part: drains the queue into the output register and formats the result fields.
module mtme_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mtme_pkg::q_status_t q_status,
  input  mtme_pkg::result_t   pop_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic [15:0]         out_bank,
  output logic [7:0]          out_sound_number,
  output logic [15:0]         out_payload_length,
  output logic [7:0]          out_payload_byte,
  output logic                out_record_last
);

  logic              out_valid_r, out_valid_nxt;
  mtme_pkg::result_t entry_r;
  logic              load;
  logic              is_hdr;

  assign load = !out_valid_r || !out_stall;
  assign pop  = load && !q_status.empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = !q_status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      entry_r <= pop_entry;
    end
  end

  assign is_hdr             = (entry_r.kind == mtme_pkg::KIND_HEADER);
  assign out_valid          = out_valid_r;
  assign out_kind           = entry_r.kind;
  assign out_bank           = is_hdr ? entry_r.bank : 16'd0;
  assign out_payload_length = is_hdr ? entry_r.plen : 16'd0;
  assign out_sound_number   = is_hdr ? entry_r.data : 8'd0;
  assign out_payload_byte   = is_hdr ? 8'd0 : entry_r.data;
  assign out_record_last    = entry_r.last;

endmodule
